// File: sv/ctlo_pkg.sv
// Package for the Cartesian tree level-order block.
// Holds the channel word types, the memory word types and shared constants.
// No dependencies.
package ctlo_pkg;

  localparam int KEY_W            = 32;
  localparam int POS_W            = 6;
  localparam int LINK_W           = 7;
  localparam int CNT_W            = 7;
  localparam int MAX_ELEMENTS_DEF = 64;

  // link code for an absent child
  localparam logic [LINK_W-1:0] NO_CHILD = 7'd64;

  typedef struct packed {
    logic signed [KEY_W-1:0] value;
    logic                    final_item;
  } in_word_t;

  typedef struct packed {
    logic [POS_W-1:0] node_position;
    logic [POS_W-1:0] node_depth;
    logic             run_end;
    logic             overflow;
  } out_word_t;

  // one tree node: key and both child links
  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [LINK_W-1:0]       left;
    logic [LINK_W-1:0]       right;
  } node_word_t;

  // stack entry while building, queue entry while walking
  typedef struct packed {
    logic [POS_W-1:0] node;
    logic [POS_W-1:0] depth;
  } stack_word_t;

endpackage

// File: sv/ctlo_ram.sv
// Simple dual-port synchronous RAM, one write and one read port.
// Read data is registered. No dependencies.
module ctlo_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: sv/cartesian_tree_level_order_top.sv
// Cartesian tree builder with breadth-first readout; uses ctlo_pkg and ctlo_ram.
// Insert: read the stack top and its node, pop while the top key is greater, then push.
// Final word: insert, a setup step that seeds the queue with the root, then per node
// emitted: queue read, node read, two queue pushes, output load (waits while the output stalls).
// One word at a time; a dropped non-final word leaves the block idle for the next word.
// Reset (rst_n low, synchronous) clears counters and flags at once; no memory sweep.
module cartesian_tree_level_order_top
  import ctlo_pkg::*;
#(
  parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ELEMENTS);

  typedef enum logic [3:0] {
    S_IDLE, S_STK, S_KEY, S_PUSH, S_E_INIT, S_E_QRD, S_E_NRD, S_E_KIDS, S_E_RKID, S_E_OUT
  } state_t;

  state_t                  state_r, state_nxt;
  logic signed [KEY_W-1:0] key_r, key_nxt;
  logic                    final_r, final_nxt;
  logic [CNT_W-1:0]        fill_r, fill_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [POS_W-1:0]        root_r, root_nxt;
  logic                    drop_r, drop_nxt;
  logic [LINK_W-1:0]       last_r, last_nxt;
  logic [POS_W-1:0]        top_r, top_nxt;
  logic [CNT_W-1:0]        head_r, head_nxt;
  logic [CNT_W-1:0]        tail_r, tail_nxt;
  logic [POS_W-1:0]        cur_r, cur_nxt;
  logic [POS_W-1:0]        depth_r, depth_nxt;
  logic [LINK_W-1:0]       right_r, right_nxt;
  logic                    out_valid_r, out_valid_nxt;
  out_word_t               out_data_r, out_data_nxt;

  logic              node_we, stk_we;
  logic [AW-1:0]     node_waddr, node_raddr, stk_waddr, stk_raddr;
  node_word_t        node_wdata, node_q;
  stack_word_t       stk_wdata, stk_q;
  logic [CNT_W-1:0]  fill_m1, fill_m2;
  logic [POS_W-1:0]  depth_p1;
  logic              last_node;

  assign fill_m1   = fill_r - CNT_W'(1);
  assign fill_m2   = fill_r - CNT_W'(2);
  assign depth_p1  = depth_r + POS_W'(1);
  assign last_node = (head_r + CNT_W'(1)) == count_r;

  // node store: key and child links
  ctlo_ram #(.WIDTH($bits(node_word_t)), .DEPTH(MAX_ELEMENTS), .AW(AW)) u_node_ram (
    .clk     (clk),
    .wr_en   (node_we),
    .wr_addr (node_waddr),
    .wr_data (node_wdata),
    .rd_addr (node_raddr),
    .rd_data (node_q)
  );

  // index stack while building, breadth-first queue while walking
  ctlo_ram #(.WIDTH($bits(stack_word_t)), .DEPTH(MAX_ELEMENTS), .AW(AW)) u_stk_ram (
    .clk     (clk),
    .wr_en   (stk_we),
    .wr_addr (stk_waddr),
    .wr_data (stk_wdata),
    .rd_addr (stk_raddr),
    .rd_data (stk_q)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // sequencer: insert by popping the stack, then walk the tree level by level
  always_comb begin
    state_nxt     = state_r;
    key_nxt       = key_r;
    final_nxt     = final_r;
    fill_nxt      = fill_r;
    count_nxt     = count_r;
    root_nxt      = root_r;
    drop_nxt      = drop_r;
    last_nxt      = last_r;
    top_nxt       = top_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    cur_nxt       = cur_r;
    depth_nxt     = depth_r;
    right_nxt     = right_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    node_we       = 1'b0;
    node_waddr    = '0;
    node_wdata    = '0;
    node_raddr    = '0;
    stk_we        = 1'b0;
    stk_waddr     = '0;
    stk_wdata     = '0;
    stk_raddr     = '0;

    // drop the output word once taken
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          key_nxt   = in_data.value;
          final_nxt = in_data.final_item;
          last_nxt  = NO_CHILD;
          if (count_r >= MAX_CNT) begin
            drop_nxt  = 1'b1;
            state_nxt = in_data.final_item ? S_E_INIT : S_IDLE;
          end else if (fill_r != '0) begin
            stk_raddr = fill_m1[AW-1:0];
            state_nxt = S_STK;
          end else begin
            state_nxt = S_PUSH;
          end
        end
      end
      S_STK: begin
        // stack top is out; fetch its node
        top_nxt    = stk_q.node;
        node_raddr = stk_q.node[AW-1:0];
        state_nxt  = S_KEY;
      end
      S_KEY: begin
        if (node_q.key > key_r) begin
          // pop the greater entry
          last_nxt = {1'b0, top_r};
          fill_nxt = fill_m1;
          if (fill_r > CNT_W'(1)) begin
            stk_raddr = fill_m2[AW-1:0];
            state_nxt = S_STK;
          end else begin
            state_nxt = S_PUSH;
          end
        end else begin
          // new node hangs right of the remaining top
          node_we          = 1'b1;
          node_waddr       = top_r[AW-1:0];
          node_wdata.key   = node_q.key;
          node_wdata.left  = node_q.left;
          node_wdata.right = {1'b0, count_r[POS_W-1:0]};
          state_nxt        = S_PUSH;
        end
      end
      S_PUSH: begin
        node_we          = 1'b1;
        node_waddr       = count_r[AW-1:0];
        node_wdata.key   = key_r;
        node_wdata.left  = last_r;
        node_wdata.right = NO_CHILD;
        stk_we           = 1'b1;
        stk_waddr        = fill_r[AW-1:0];
        stk_wdata.node   = count_r[POS_W-1:0];
        stk_wdata.depth  = '0;
        if (fill_r == '0) begin
          root_nxt = count_r[POS_W-1:0];
        end
        fill_nxt  = fill_r + CNT_W'(1);
        count_nxt = count_r + CNT_W'(1);
        state_nxt = final_r ? S_E_INIT : S_IDLE;
      end
      S_E_INIT: begin
        // seed the queue with the root
        stk_we          = 1'b1;
        stk_waddr       = '0;
        stk_wdata.node  = root_r;
        stk_wdata.depth = '0;
        head_nxt        = '0;
        tail_nxt        = CNT_W'(1);
        state_nxt       = S_E_QRD;
      end
      S_E_QRD: begin
        stk_raddr = head_r[AW-1:0];
        state_nxt = S_E_NRD;
      end
      S_E_NRD: begin
        cur_nxt    = stk_q.node;
        depth_nxt  = stk_q.depth;
        node_raddr = stk_q.node[AW-1:0];
        state_nxt  = S_E_KIDS;
      end
      S_E_KIDS: begin
        right_nxt = node_q.right;
        if (node_q.left < count_r) begin
          stk_we          = 1'b1;
          stk_waddr       = tail_r[AW-1:0];
          stk_wdata.node  = node_q.left[POS_W-1:0];
          stk_wdata.depth = depth_p1;
          tail_nxt        = tail_r + CNT_W'(1);
        end
        state_nxt = S_E_RKID;
      end
      S_E_RKID: begin
        if (right_r < count_r) begin
          stk_we          = 1'b1;
          stk_waddr       = tail_r[AW-1:0];
          stk_wdata.node  = right_r[POS_W-1:0];
          stk_wdata.depth = depth_p1;
          tail_nxt        = tail_r + CNT_W'(1);
        end
        state_nxt = S_E_OUT;
      end
      S_E_OUT: begin
        // load the output word when the register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.node_position = cur_r;
          out_data_nxt.node_depth    = depth_r;
          out_data_nxt.run_end       = last_node;
          out_data_nxt.overflow      = drop_r;
          head_nxt                   = head_r + CNT_W'(1);
          if (last_node) begin
            count_nxt = '0;
            fill_nxt  = '0;
            root_nxt  = '0;
            drop_nxt  = 1'b0;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_E_QRD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      count_r     <= '0;
      root_r      <= '0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      count_r     <= count_nxt;
      root_r      <= root_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= out_valid_nxt;
    end
    key_r      <= key_nxt;
    final_r    <= final_nxt;
    last_r     <= last_nxt;
    top_r      <= top_nxt;
    head_r     <= head_nxt;
    tail_r     <= tail_nxt;
    cur_r      <= cur_nxt;
    depth_r    <= depth_nxt;
    right_r    <= right_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// File: sv/ctlo_checker.sv
// Port-level checks for cartesian_tree_level_order_top, bound to the top level.
// Uses ctlo_pkg for the channel word types.
module ctlo_props
  import ctlo_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_word_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_word_t out_data
);

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output word changed while stalled");

  // a final word always starts a readout, so the input is busy next
  a_final_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.final_item |=> in_stall)
    else $error("input not stalled after final word");

  // overflow flag is the same on every node of one run
  a_ovf_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.run_end |=>
      !out_valid || (out_data.overflow == $past(out_data.overflow)))
    else $error("overflow flag changed within a run");

  // level order: depth never decreases within a run
  a_depth_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.run_end |=>
      !out_valid || (out_data.node_depth >= $past(out_data.node_depth)))
    else $error("node depth decreased within a run");

endmodule

bind cartesian_tree_level_order_top ctlo_props u_ctlo_props (.*);

// File: tb/ctlo_checker.sv
// Checker for the Cartesian tree level-order block: watches both channels,
// rebuilds each tree from the accepted key words, and compares the emitted nodes.
// Depends on ctlo_pkg for the word types and sizes.
module ctlo_checker
  import ctlo_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_word_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_word_t out_data,
  output int        fail_count,
  output int        nodes_pending,
  output int        nodes_seen
);

  // shadow copy of the tree under construction
  logic signed [KEY_W-1:0] key_mem   [MAX_ELEMENTS_DEF];
  logic [LINK_W-1:0]       left_mem  [MAX_ELEMENTS_DEF];
  logic [LINK_W-1:0]       right_mem [MAX_ELEMENTS_DEF];
  logic [POS_W-1:0]        spine     [MAX_ELEMENTS_DEF];
  int                      spine_fill;
  int                      held;
  logic [POS_W-1:0]        root_pos;
  logic                    dropped;

  out_word_t expected_nodes[$];

  // Add one key: pop larger keys off the right spine, hook up both links.
  task automatic insert_key(input logic signed [KEY_W-1:0] key);
    logic [LINK_W-1:0] last_popped;
    logic [POS_W-1:0]  pos;
    last_popped = NO_CHILD;
    if (held >= MAX_ELEMENTS_DEF) begin
      dropped = 1'b1;
      return;
    end
    pos          = held[POS_W-1:0];
    key_mem[pos] = key;
    while (spine_fill > 0 && key_mem[spine[spine_fill-1]] > key) begin
      last_popped = {1'b0, spine[spine_fill-1]};
      spine_fill--;
    end
    if (spine_fill > 0) begin
      right_mem[spine[spine_fill-1]] = {1'b0, pos};
    end else begin
      root_pos = pos;
    end
    left_mem[pos]     = last_popped;
    right_mem[pos]    = NO_CHILD;
    spine[spine_fill] = pos;
    spine_fill++;
    held++;
  endtask

  // Walk the tree breadth-first, left before right, and queue one node word each.
  task automatic walk_tree();
    logic [POS_W-1:0]  order [MAX_ELEMENTS_DEF];
    logic [POS_W-1:0]  level [MAX_ELEMENTS_DEF];
    logic [LINK_W-1:0] kid;
    logic [POS_W-1:0]  node;
    out_word_t         w;
    int                head;
    int                tail;
    if (held > 0) begin
      order[0] = root_pos;
      level[0] = '0;
      head     = 0;
      tail     = 1;
      while (head < tail) begin
        node = order[head];
        for (int k = 0; k < 2; k++) begin
          kid = (k == 0) ? left_mem[node] : right_mem[node];
          if (kid < held) begin
            order[tail] = kid[POS_W-1:0];
            level[tail] = level[head] + 1'b1;
            tail++;
          end
        end
        w.node_position = node;
        w.node_depth    = level[head];
        w.run_end       = (head == tail - 1);
        w.overflow      = dropped;
        expected_nodes.push_back(w);
        head++;
      end
    end
    held       = 0;
    spine_fill = 0;
    root_pos   = '0;
    dropped    = 1'b0;
  endtask

  // Compare one emitted node word against the oldest expectation.
  task automatic check_node(input out_word_t got);
    out_word_t want;
    if (expected_nodes.size() == 0) begin
      $error("unexpected node word: position %0d depth %0d", got.node_position,
             got.node_depth);
      fail_count++;
      return;
    end
    want = expected_nodes.pop_front();
    if (got.node_position !== want.node_position) begin
      $error("node_position: expected %0d, got %0d", want.node_position, got.node_position);
      fail_count++;
    end
    if (got.node_depth !== want.node_depth) begin
      $error("node_depth: expected %0d, got %0d", want.node_depth, got.node_depth);
      fail_count++;
    end
    if (got.run_end !== want.run_end) begin
      $error("run_end: expected %0b, got %0b", want.run_end, got.run_end);
      fail_count++;
    end
    if (got.overflow !== want.overflow) begin
      $error("overflow: expected %0b, got %0b", want.overflow, got.overflow);
      fail_count++;
    end
  endtask

  // Check outputs before taking the new key, so a stray word is never masked.
  always @(posedge clk) begin
    if (!rst_n) begin
      held       = 0;
      spine_fill = 0;
      root_pos   = '0;
      dropped    = 1'b0;
      fail_count = 0;
      nodes_seen = 0;
      expected_nodes.delete();
    end else begin
      if (out_valid && !out_stall) begin
        check_node(out_data);
        nodes_seen++;
      end
      if (in_valid && !in_stall) begin
        insert_key(in_data.value);
        if (in_data.final_item) walk_tree();
      end
    end
    nodes_pending = expected_nodes.size();
  end

endmodule

// File: tb/tb.sv
// Top of the Cartesian tree level-order testbench: clock, reset, key stimulus,
// output stalls, watchdog and verdict. Depends on ctlo_pkg, the block and ctlo_checker.
module tb;
  import ctlo_pkg::*;

  localparam int ITEM_TARGET    = 280;
  localparam int QUIET_FROM     = 240;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 50;

  typedef enum int {KEYS_ANY, KEYS_NARROW, KEYS_RISING, KEYS_FALLING} key_mix_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_data;

  int fail_count;
  int nodes_pending;
  int nodes_seen;
  int words_sent;
  int runs_sent;
  int overflow_runs;
  int idle_count;
  logic quiet;
  logic hold_long;

  cartesian_tree_level_order_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  ctlo_checker u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .fail_count    (fail_count),
    .nodes_pending (nodes_pending),
    .nodes_seen    (nodes_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stall the output in short random bursts, or once for a long stretch on request.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_long) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_long = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Abort when no word moves on either channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_count <= 0;
    end else if (idle_count >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no word moved for %0d cycles", idle_count);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  // Offer one key word, with an optional random gap first; return once accepted.
  task automatic push_word(input logic signed [KEY_W-1:0] key, input logic last);
    in_word_t w;
    w.value      = key;
    w.final_item = last;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    words_sent++;
    if (words_sent >= QUIET_FROM) quiet = 1'b1;
  endtask

  // Send a whole sequence of generated keys, the last word marked final.
  task automatic send_run(input int len, input key_mix_t mix);
    logic signed [KEY_W-1:0] key;
    int                      base;
    base = int'($urandom_range(0, 1000)) - 500;
    for (int i = 0; i < len; i++) begin
      case (mix)
        KEYS_NARROW:  key = int'($urandom_range(0, 7)) - 4;
        KEYS_RISING:  key = base + i;
        KEYS_FALLING: key = base - i;
        default:      key = $urandom;
      endcase
      push_word(key, i == len - 1);
    end
    runs_sent++;
    if (len > MAX_ELEMENTS_DEF) overflow_runs++;
  endtask

  // Hold the sender idle until every expected node word has come out.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (nodes_pending != 0);
    @(posedge clk);
  endtask

  // Send a fixed list of keys as one sequence.
  task automatic send_list(input logic signed [KEY_W-1:0] keys[$]);
    for (int i = 0; i < keys.size(); i++) push_word(keys[i], i == keys.size() - 1);
    runs_sent++;
  endtask

  initial begin
    int       len;
    key_mix_t mix;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_data       <= '0;
    quiet         = 1'b0;
    hold_long     = 1'b0;
    words_sent    = 0;
    runs_sent     = 0;
    overflow_runs = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: single node, extreme keys, equal keys, mixed pops
    send_list('{0});
    send_list('{32'sh7FFF_FFFF, 32'sh8000_0000});
    send_list('{32'sh8000_0000, 32'sh7FFF_FFFF, 0, -1, -1});
    send_list('{7, 7, 7});
    send_list('{3, 1, 2, 0, 5, 4});

    // full rising chain reaches the deepest node, then an overflowing run
    send_run(MAX_ELEMENTS_DEF, KEYS_RISING);
    send_run(MAX_ELEMENTS_DEF + $urandom_range(1, 6), KEYS_ANY);

    // random runs, mostly short, now and then long enough to overflow
    while (words_sent < ITEM_TARGET) begin
      if (runs_sent == 9) hold_long = 1'b1;
      if (runs_sent == 14) wait_for_results();
      if ($urandom_range(0, 15) == 0) len = $urandom_range(20, 70);
      else len = $urandom_range(1, 12);
      mix = key_mix_t'($urandom_range(0, 3));
      send_run(len, mix);
    end
    in_valid <= 1'b0;

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d key words in %0d sequences, %0d of them overflowing;",
             words_sent, runs_sent, overflow_runs);
    $display("checked %0d node words in level order.", nodes_seen);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
